// ===== sv/gcsc_pkg.sv =====
// Package: shared constants and types for the greedy coin system checker.
`default_nettype none
package gcsc_pkg;
   localparam int MaxCoins   = 128;
   localparam int CoinBits   = 16;
   localparam int AmountBits = 17;
   localparam logic [AmountBits-1:0] AmountMax = '1;

   typedef struct packed {
      logic load_start;   // begin insertion of the latched coin
      logic test_start;   // begin the canonical test
      logic clear;        // empty the table
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } stat_type;
endpackage
`default_nettype wire

// ===== sv/gcsc_if.sv =====
// Interfaces: valid/ready channels for coin requests and test responses.
`default_nettype none
interface gcsc_req_if #(parameter int CoinBits = gcsc_pkg::CoinBits);
   logic                valid;
   logic                ready;
   logic [CoinBits-1:0] coin_value;
   logic                last_coin;
   modport source (output valid, coin_value, last_coin, input ready);
   modport sink   (input valid, coin_value, last_coin, output ready);
endinterface

interface gcsc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [gcsc_pkg::AmountBits-1:0]   counterexample;
   logic                              is_canonical;
   modport source (output valid, counterexample, is_canonical, input ready);
   modport sink   (input valid, counterexample, is_canonical, output ready);
endinterface
`default_nettype wire

// ===== sv/gcsc_datapath.sv =====
// Datapath: sorted coin memory, insertion sweep and sequential Pearson test.
`default_nettype none
module gcsc_datapath #(
   parameter int MaxCoins = gcsc_pkg::MaxCoins,
   parameter int CoinBits = gcsc_pkg::CoinBits
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire gcsc_pkg::cmd_type               cmd,
   input  wire logic [CoinBits-1:0]             coin_in,
   output gcsc_pkg::stat_type                   stat,
   output logic [gcsc_pkg::AmountBits-1:0]      best_out
);
   localparam int IdxBits = (MaxCoins > 1) ? $clog2(MaxCoins) : 1;
   localparam int CntBits = $clog2(MaxCoins + 1);
   localparam int AB      = gcsc_pkg::AmountBits;
   localparam int WB      = (CoinBits > AB) ? CoinBits + 1 : AB + 1;
   localparam int DivBits = AB + 1;

   typedef enum logic [3:0] {
      S_IDLE, S_INS_RD, S_INS_CMP, S_INS_WR,
      S_T_I, S_PRE_RD, S_PRE_DIV, S_J_RD, S_J_MUL, S_J_ADD,
      S_G_RD, S_G_DIV, S_J_NEXT, S_DONE
   } st_type;

   logic [CoinBits-1:0] coin_mem [MaxCoins];
   logic [AB-1:0]       pre_mem  [MaxCoins];

   st_type               st_ff, st_in;
   logic [CntBits-1:0]   count_ff, count_in;
   logic [CntBits-1:0]   pos_ff, pos_in;
   logic [CntBits-1:0]   i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [CoinBits-1:0]  v_ff, v_in;
   logic [CoinBits-1:0]  rd_ff;
   logic [AB-1:0]        pre_rd_ff;
   logic [CntBits-1:0]   raddr;
   logic [IdxBits-1:0]   coin_waddr, pre_waddr;
   logic [CoinBits-1:0]  coin_wdata;
   logic                 coin_we, pre_we;
   logic [AB-1:0]        pre_wdata;
   logic [WB-1:0]        x_ff, x_in;
   logic [AB-1:0]        tot_ff, tot_in;
   logic [AB-1:0]        part_ff, part_in, size_ff, size_in, w_ff, w_in;
   logic [AB-1:0]        best_ff, best_in;
   logic [WB+CoinBits-1:0] prod_ff, prod_in;
   logic [WB-1:0]        rem_ff, rem_in;
   logic [DivBits-1:0]   quo_ff, quo_in;
   logic [$clog2(WB+1)-1:0] bit_ff, bit_in;
   logic [WB:0]          trial;
   logic [WB+CoinBits:0] sum_w;
   logic                 pre_mode_ff, pre_mode_in;

   function automatic logic [AB-1:0] sat(input logic [WB+CoinBits:0] v);
      return (v > (WB+CoinBits+1)'(gcsc_pkg::AmountMax)) ? gcsc_pkg::AmountMax : AB'(v);
   endfunction

   always_ff @(posedge clock) begin
      rd_ff     <= coin_mem[raddr[IdxBits-1:0]];
      pre_rd_ff <= pre_mem[raddr[IdxBits-1:0]];
      if (coin_we) coin_mem[coin_waddr] <= coin_wdata;
      if (pre_we)  pre_mem[pre_waddr]   <= pre_wdata;
   end

   // bit-serial restoring divide of x by rd_ff
   assign trial = {rem_ff, x_ff[bit_ff - 1'b1]};

   always_comb begin
      st_in = st_ff; count_in = count_ff; pos_in = pos_ff; v_in = v_ff;
      i_in = i_ff; j_in = j_ff; k_in = k_ff; x_in = x_ff; tot_in = tot_ff;
      part_in = part_ff; size_in = size_ff; w_in = w_ff; best_in = best_ff;
      prod_in = prod_ff; rem_in = rem_ff; quo_in = quo_ff; bit_in = bit_ff;
      pre_mode_in = pre_mode_ff;
      raddr = '0; coin_we = 1'b0; coin_waddr = '0; coin_wdata = v_ff;
      pre_we = 1'b0; pre_waddr = '0; pre_wdata = '0; sum_w = '0;
      unique case (st_ff)
         S_IDLE: begin
            if (cmd.clear) count_in = '0;
            if (cmd.load_start) begin
               v_in = coin_in;
               pos_in = count_ff;
               if (coin_in != '0 && count_ff < CntBits'(MaxCoins)) st_in = S_INS_RD;
               else st_in = S_DONE;
            end else if (cmd.test_start) begin
               best_in = '0; i_in = '0; st_in = S_T_I;
            end
         end
         S_INS_RD: begin
            if (pos_ff == '0) st_in = S_INS_WR;
            else begin raddr = pos_ff - 1'b1; st_in = S_INS_CMP; end
         end
         S_INS_CMP: begin
            if (rd_ff < v_ff) begin
               coin_we = 1'b1; coin_waddr = IdxBits'(pos_ff); coin_wdata = rd_ff;
               pos_in = pos_ff - 1'b1; st_in = S_INS_RD;
            end else st_in = S_INS_WR;
         end
         S_INS_WR: begin
            coin_we = 1'b1; coin_waddr = IdxBits'(pos_ff);
            count_in = count_ff + 1'b1; st_in = S_DONE;
         end
         S_T_I: begin
            if (CntBits'(i_ff + 1'b1) < count_ff && i_ff + 1'b1 != '0) begin
               raddr = i_ff; k_in = '0; pre_mode_in = 1'b1; st_in = S_PRE_RD;
            end else st_in = S_DONE;
         end
         S_PRE_RD: begin
            x_in = WB'(rd_ff) - 1'b1;
            if (rd_ff == '0) x_in = '1;
            raddr = '0; tot_in = '0; st_in = S_G_RD;
         end
         S_G_RD: begin
            raddr = k_ff;
            rem_in = '0; quo_in = '0; bit_in = ($clog2(WB+1))'(WB); st_in = S_G_DIV;
            if (rd_ff == '0) begin bit_in = '0; end
         end
         S_G_DIV: begin
            raddr = k_ff;
            if (bit_ff != '0) begin
               if (trial >= (WB+1)'(rd_ff)) begin
                  rem_in = WB'(trial - (WB+1)'(rd_ff));
                  quo_in = {quo_ff[DivBits-2:0], 1'b1};
               end else begin
                  rem_in = WB'(trial); quo_in = {quo_ff[DivBits-2:0], 1'b0};
               end
               if (quo_ff[DivBits-1]) quo_in = '1;
               bit_in = bit_ff - 1'b1;
            end else begin
               if (rd_ff != '0) x_in = rem_ff;
               sum_w = (WB+CoinBits+1)'(tot_ff) + (WB+CoinBits+1)'(sat(
                       (WB+CoinBits+1)'(quo_ff)));
               tot_in = sat(sum_w);
               if (pre_mode_ff) begin
                  pre_we = 1'b1; pre_waddr = IdxBits'(k_ff);
                  pre_wdata = sat((WB+CoinBits+1)'(quo_ff));
               end
               if (k_ff + 1'b1 < count_ff && k_ff + 1'b1 != '0) begin
                  k_in = k_ff + 1'b1; raddr = k_ff + 1'b1; st_in = S_G_RD;
               end else if (pre_mode_ff) begin
                  pre_mode_in = 1'b0; part_in = '0; size_in = AB'(1);
                  j_in = i_ff + 1'b1; raddr = i_ff + 1'b1; st_in = S_J_RD;
               end else begin
                  if (tot_in > size_ff && (best_ff == '0 || w_ff < best_ff))
                     best_in = w_ff;
                  st_in = S_J_NEXT;
               end
            end
         end
         S_J_MUL: begin
            raddr = j_ff;
            prod_in = (WB+CoinBits)'(pre_rd_ff) * (WB+CoinBits)'(rd_ff);
            st_in = S_J_ADD;
         end
         S_J_ADD: begin
            sum_w = (WB+CoinBits+1)'(part_ff) + (WB+CoinBits+1)'(prod_ff);
            part_in = sat(sum_w);
            w_in = sat((WB+CoinBits+1)'(part_in) + (WB+CoinBits+1)'(rd_ff));
            size_in = sat((WB+CoinBits+1)'(size_ff) + (WB+CoinBits+1)'(pre_rd_ff));
            x_in = WB'(w_in); tot_in = '0; k_in = '0; raddr = '0; st_in = S_G_RD;
         end
         S_J_NEXT: begin
            if (j_ff + 1'b1 < count_ff && j_ff + 1'b1 != '0) begin
               j_in = j_ff + 1'b1; raddr = j_ff + 1'b1; st_in = S_J_RD;
            end else begin i_in = i_ff + 1'b1; st_in = S_T_I; end
         end
         S_J_RD: begin
            raddr = j_ff; st_in = S_J_MUL;
         end
         S_DONE: st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; count_ff <= '0; best_ff <= '0;
      end else begin
         st_ff <= st_in; count_ff <= count_in; best_ff <= best_in;
      end
      pos_ff <= pos_in; v_ff <= v_in; i_ff <= i_in; j_ff <= j_in; k_ff <= k_in;
      x_ff <= x_in; tot_ff <= tot_in; part_ff <= part_in; size_ff <= size_in;
      w_ff <= w_in; prod_ff <= prod_in; rem_ff <= rem_in; quo_ff <= quo_in;
      bit_ff <= bit_in; pre_mode_ff <= pre_mode_in;
   end

   assign stat.busy = (st_ff != S_IDLE);
   assign stat.done = (st_ff == S_DONE);
   assign best_out  = best_ff;
endmodule
`default_nettype wire

// ===== sv/gcsc_ctrl.sv =====
// Controller: handshakes and sequencing of load and test commands.
`default_nettype none
module gcsc_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_last,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output gcsc_pkg::cmd_type       cmd,
   input  wire gcsc_pkg::stat_type stat
);
   typedef enum logic [2:0] {C_IDLE, C_LOAD, C_TEST_GO, C_TEST, C_OUT} cst_type;
   cst_type st_ff;
   logic    last_ff;

   assign req_ready = (st_ff == C_IDLE);
   assign rsp_valid = (st_ff == C_OUT);

   always_comb begin
      cmd.load_start = (st_ff == C_IDLE) && req_valid;
      cmd.test_start = (st_ff == C_TEST_GO);
      cmd.clear      = (st_ff == C_OUT) && rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= C_IDLE; last_ff <= 1'b0;
      end else begin
         unique case (st_ff)
            C_IDLE:    if (req_valid) begin last_ff <= req_last; st_ff <= C_LOAD; end
            C_LOAD:    if (stat.done) st_ff <= last_ff ? C_TEST_GO : C_IDLE;
            C_TEST_GO: st_ff <= C_TEST;
            C_TEST:    if (stat.done) st_ff <= C_OUT;
            C_OUT:     if (rsp_ready) st_ff <= C_IDLE;
            default:   st_ff <= C_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== sv/greedy_coin_system_counterexample.sv =====
// Top level: greedy coin system checker (Pearson canonical test).
//  channel | dir | payload
//  req     | in  | coin_value[COIN_BITS], last_coin
//  rsp     | out | counterexample[17], is_canonical
// One coin at a time; insertion shifts smaller coins along the sorted memory (memory sweep).
// The test runs a greedy pass for each candidate amount: each greedy pass divides by every
// coin on one 18-step serial divider.
// Synchronous reset empties the coin table; memories are not cleared.
// A held response blocks new requests until taken.
`default_nettype none
module greedy_coin_system_counterexample #(
   parameter int MAX_COINS = gcsc_pkg::MaxCoins,
   parameter int COIN_BITS = gcsc_pkg::CoinBits
) (
   input wire logic clock,
   input wire logic reset,
   gcsc_req_if.sink   req,
   gcsc_rsp_if.source rsp
);
   gcsc_pkg::cmd_type  cmd;
   gcsc_pkg::stat_type stat;
   logic [gcsc_pkg::AmountBits-1:0] best;

   gcsc_ctrl u_ctrl (
      .clock, .reset, .req_valid(req.valid), .req_last(req.last_coin),
      .req_ready(req.ready), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .cmd, .stat
   );

   gcsc_datapath #(.MaxCoins(MAX_COINS), .CoinBits(COIN_BITS)) u_dp (
      .clock, .reset, .cmd, .coin_in(req.coin_value), .stat, .best_out(best)
   );

   assign rsp.counterexample = best;
   assign rsp.is_canonical   = (best == '0);

`ifndef SYNTHESIS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req.ready && rsp.valid)) else $error("ready during response");
   a_canon: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.is_canonical == (rsp.counterexample == '0)))
      else $error("flag mismatch");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> $stable(rsp.counterexample))
      else $error("response changed");
`endif
endmodule
`default_nettype wire

// ===== verif/greedy_coin_system_counterexample_tb.sv =====
// Testbench: greedy coin system checker, fixed and random coin sets against a local predictor.
`default_nettype none
module greedy_coin_system_counterexample_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MaxCoins   = gcsc_pkg::MaxCoins;
   localparam int CoinBits   = gcsc_pkg::CoinBits;
   localparam int AmountBits = gcsc_pkg::AmountBits;

   typedef longint unsigned u64_type;
   typedef struct packed {
      logic [CoinBits-1:0] coin;
      logic                last;
   } coin_txn_type;
   typedef struct packed {
      logic [AmountBits-1:0] amount;
      logic                  canon;
   } verdict_type;

   localparam u64_type SatLimit = u64_type'(gcsc_pkg::AmountMax);
   localparam int CycleLimit = 10_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycle_cnt = 0;
   int   err_cnt = 0;

   gcsc_req_if req ();
   gcsc_rsp_if rsp ();

   greedy_coin_system_counterexample u_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source)
   );

   coin_txn_type pending_coins[$];
   verdict_type  expected_verdicts[$];

   u64_type sorted_coins[MaxCoins];
   u64_type cand_rep[MaxCoins];
   u64_type pre_rep[MaxCoins];
   int loaded = 0;

   function automatic u64_type sat(u64_type v);
      return (v > SatLimit) ? SatLimit : v;
   endfunction

   function automatic u64_type greedy_change(u64_type x, output u64_type rep[MaxCoins]);
      u64_type total;
      u64_type q;
      total = 0;
      for (int k = 0; k < loaded; k++) begin
         q = x / sorted_coins[k];
         x = x % sorted_coins[k];
         rep[k] = sat(q);
         total = sat(total + rep[k]);
      end
      return total;
   endfunction

   function automatic u64_type smallest_counterexample();
      u64_type best, partial, size, w, g, dummy;
      best = 0;
      for (int i = 0; i + 1 < loaded; i++) begin
         partial = 0;
         size = 1;
         dummy = greedy_change(sorted_coins[i] - 1, pre_rep);
         for (int j = i + 1; j < loaded; j++) begin
            partial = sat(partial + pre_rep[j] * sorted_coins[j]);
            w = sat(partial + sorted_coins[j]);
            size = sat(size + pre_rep[j]);
            g = greedy_change(w, cand_rep);
            if (g > size && (best == 0 || w < best)) best = w;
         end
      end
      return best;
   endfunction

   task automatic absorb_coin(coin_txn_type t);
      int pos;
      u64_type v;
      verdict_type r;
      v = u64_type'(t.coin);
      if (v != 0 && loaded < MaxCoins) begin
         pos = loaded;
         while (pos > 0 && sorted_coins[pos-1] < v) begin
            sorted_coins[pos] = sorted_coins[pos-1];
            pos--;
         end
         sorted_coins[pos] = v;
         loaded++;
      end
      if (t.last) begin
         v = smallest_counterexample();
         r.amount = v[AmountBits-1:0];
         r.canon = (v == 0);
         expected_verdicts.push_back(r);
         loaded = 0;
      end
   endtask

   task automatic report(string what, int got, int want);
      $display("mismatch @%0d: %s got %0d expected %0d", cycle_cnt, what, got, want);
      err_cnt++;
   endtask

   task automatic add_set(int n, bit wide);
      coin_txn_type t;
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 19) == 0) t.coin = '0;
         else if (wide) t.coin = CoinBits'($urandom_range(1, 65535));
         else t.coin = CoinBits'($urandom_range(1, 40));
         t.last = (k == n - 1);
         pending_coins.push_back(t);
      end
   endtask

   task automatic add_fixed(int vals[$]);
      coin_txn_type t;
      foreach (vals[k]) begin
         t.coin = CoinBits'(vals[k]);
         t.last = (k == vals.size() - 1);
         pending_coins.push_back(t);
      end
   endtask

   function automatic bit idle_now();
      if (cycle_cnt > 30000 && cycle_cnt < 90000) return 1'b0;
      return $urandom_range(0, 99) < 14;
   endfunction

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CycleLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   bit req_taken = 1'b0;
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset && req.valid && req.ready) begin
         absorb_coin('{coin: req.coin_value, last: req.last_coin});
         req_taken = 1'b1;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else if (!req.valid || req_taken) begin
         if (pending_coins.size() > 0 && !idle_now()) begin
            req.coin_value <= pending_coins[0].coin;
            req.last_coin <= pending_coins[0].last;
            req.valid <= 1'b1;
            void'(pending_coins.pop_front());
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   int hold_left = 0;
   bit hold_done = 1'b0;
   always @(negedge clock) begin
      if (!hold_done && cycle_cnt > 5000 && rsp.valid) begin
         hold_left = 4000;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= !idle_now();
      end
   end

   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_verdicts.size() == 0) begin
            report("unexpected transaction", int'(rsp.counterexample), -1);
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp.counterexample !== want.amount)
               report("counterexample", int'(rsp.counterexample), int'(want.amount));
            if (rsp.is_canonical !== want.canon)
               report("is_canonical", int'(rsp.is_canonical), int'(want.canon));
         end
      end
   end

   initial begin
      req.valid = 1'b0;
      req.coin_value = '0;
      req.last_coin = 1'b0;
      rsp.ready = 1'b0;
      add_fixed('{65535});
      add_fixed('{0});
      add_fixed('{1, 3, 4});
      add_fixed('{25, 10, 5, 1});
      add_fixed('{5, 5, 1});
      add_fixed('{3, 5});
      add_fixed('{65535, 65534, 1});
      add_fixed('{1, 0, 7, 65535});
      while (pending_coins.size() < 2000) begin
         if ($urandom_range(0, 9) == 0) add_set($urandom_range(5, 8), $urandom_range(0, 1));
         else add_set($urandom_range(1, 4), $urandom_range(0, 2) == 0);
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      wait (pending_coins.size() == 0 && !req.valid && expected_verdicts.size() == 0);
      repeat (300) @(posedge clock);
      if (err_cnt == 0 && expected_verdicts.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
`default_nettype wire
